// File: design/mandelbrot_escape_time_pixel_unit_macros.svh
// Assertion helpers shared by the escape-time pixel modules.
// Each expects i_clk and i_rst_n in the enclosing module.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_UNIT_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_UNIT_MACROS_SVH

// Check a condition in the same cycle as its trigger
`define MBROT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define MBROT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/mbrot_pkg.sv
package mbrot_pkg;

    // Image geometry; raster positions wrap at these sizes
    localparam int IMAGE_WIDTH  = 1024;
    localparam int IMAGE_HEIGHT = 1024;

    // Field widths
    localparam int COORD_W   = 10;
    localparam int FIX_W     = 32;
    localparam int STEP_W    = 31;
    localparam int ITER_W    = 8;
    localparam int LIMIT_W   = 4;
    localparam int COLOUR_W  = 32;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC_BITS = 24;

    // z stays below 2^33 in magnitude for any escape limit up to 15
    localparam int Z_W    = 34;
    localparam int PROD_W = 2 * Z_W;
    // |z|^2 in Q.24 stays below 2^43
    localparam int MAG2_W = 43;

    // Square root of |z|^2 scaled by 2^16, one root bit per cycle
    localparam int SQRT_PRE   = 16;
    localparam int SQRT_STEPS = 30;
    localparam int RAD_W      = 2 * SQRT_STEPS;
    localparam int ROOT_W     = SQRT_STEPS;
    localparam int REM_W      = ROOT_W + 2;
    localparam int CNT_W      = $clog2(SQRT_STEPS + 1);

    // Colour scaling: floor(mod * 25601 / 2^20)
    localparam int SCALE_W     = 15;
    localparam int SCALE_SHIFT = 20;
    localparam logic [SCALE_W-1:0] COLOUR_SCALE = SCALE_W'(100 * 255 + 100 + 1);
    localparam int SCALED_W    = ROOT_W + SCALE_W - SCALE_SHIFT;

    // Register reset values
    localparam logic [FIX_W-1:0]    RST_X_START     = 32'hFE00_0000;
    localparam logic [FIX_W-1:0]    RST_Y_END       = 32'h0200_0000;
    localparam logic [STEP_W-1:0]   RST_X_STEP      = 31'd65536;
    localparam logic [STEP_W-1:0]   RST_Y_STEP      = 31'd65536;
    localparam logic [ITER_W-1:0]   RST_MAX_ITER    = 8'd50;
    localparam logic [LIMIT_W-1:0]  RST_LIMIT       = 4'd5;
    localparam logic [COLOUR_W-1:0] RST_INSIDE_BASE = 32'hFFFF_FFFF;
    localparam logic [COLOUR_W-1:0] RST_OUT_BASE    = 32'd999999990;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_START     = 3'd0,
        CFG_Y_END       = 3'd1,
        CFG_X_STEP      = 3'd2,
        CFG_Y_STEP      = 3'd3,
        CFG_MAX_ITER    = 3'd4,
        CFG_LIMIT       = 3'd5,
        CFG_INSIDE_BASE = 3'd6,
        CFG_OUT_BASE    = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_STEP,
        ST_SQRT,
        ST_SCALE,
        ST_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic setup;
        logic mul;
        logic step;
        logic sqrt_start;
        logic scale;
        logic emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic go;
        logic root_busy;
    } t_sts;

endpackage

// File: design/mbrot_isqrt.sv
`include "mandelbrot_escape_time_pixel_unit_macros.svh"

module mbrot_isqrt
    import mbrot_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAD_W-1:0]  i_radicand,
    output logic [ROOT_W-1:0] o_root,
    output logic              o_busy
);

    logic [CNT_W-1:0]  r_cnt;
    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              fits;

    // Bring down the next two radicand bits and try the next root bit
    assign rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign fits   = (rem_sh >= trial);

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(SQRT_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Restoring root, one bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_cnt != '0) begin
            r_rad <= r_rad << 2;
            if (fits) begin
                r_rem  <= REM_W'(rem_sh - trial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= REM_W'(rem_sh);
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_root = r_root;
    assign o_busy = (r_cnt != '0);

    `MBROT_ASSERT_NEXT(a_start_sets_busy, i_start, o_busy, "root unit idle after start")

endmodule

// File: design/mbrot_ctrl.sv
`include "mandelbrot_escape_time_pixel_unit_macros.svh"

module mbrot_ctrl
    import mbrot_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_SETUP;
            end
            ST_SETUP: n_state = ST_MUL;
            ST_MUL:   n_state = ST_STEP;
            ST_STEP: begin
                n_state = i_sts.go ? ST_MUL : ST_SQRT;
            end
            ST_SQRT: begin
                if (!i_sts.root_busy) n_state = ST_SCALE;
            end
            ST_SCALE: n_state = ST_EMIT;
            ST_EMIT:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE:  o_cmd.load  = i_start;
            ST_SETUP: o_cmd.setup = 1'b1;
            ST_MUL:   o_cmd.mul   = 1'b1;
            ST_STEP: begin
                o_cmd.step       = i_sts.go;
                o_cmd.sqrt_start = !i_sts.go;
            end
            ST_SQRT:  o_cmd = '0;
            ST_SCALE: o_cmd.scale = 1'b1;
            ST_EMIT:  o_cmd.emit  = 1'b1;
            default:  o_cmd = '0;
        endcase
    end

    `MBROT_ASSERT_NEXT(a_accept_sets_busy, i_start && !o_busy, o_busy, "busy low after accept")
    `MBROT_ASSERT_NEXT(a_emit_frees, o_cmd.emit, !o_busy, "busy held after result")
    `MBROT_ASSERT_NOW(a_cmd_onehot0, 1'b1, $onehot0(o_cmd), "more than one command active")

endmodule

// File: design/mbrot_dp.sv
`include "mandelbrot_escape_time_pixel_unit_macros.svh"

module mbrot_dp
    import mbrot_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [FIX_W-1:0]     i_cfg_wdata,
    input  logic [COORD_W-1:0]   i_column,
    input  logic [COORD_W-1:0]   i_row,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output logic [COLOUR_W-1:0]  o_colour,
    output logic                 o_inside_res,
    output logic [ITER_W-1:0]    o_iterations_done,
    output logic                 o_done
);

    // Configuration registers
    logic [FIX_W-1:0]    r_x_start;
    logic [FIX_W-1:0]    r_y_end;
    logic [STEP_W-1:0]   r_x_step;
    logic [STEP_W-1:0]   r_y_step;
    logic [ITER_W-1:0]   r_max_iter;
    logic [LIMIT_W-1:0]  r_limit;
    logic [COLOUR_W-1:0] r_in_base;
    logic [COLOUR_W-1:0] r_out_base;

    // Pixel work registers
    logic [COORD_W-1:0]       r_col;
    logic [COORD_W-1:0]       r_row;
    logic signed [FIX_W-1:0]  r_cr;
    logic signed [FIX_W-1:0]  r_ci;
    logic signed [Z_W-1:0]    r_zr;
    logic signed [Z_W-1:0]    r_zi;
    logic signed [PROD_W-1:0] r_p_rr;
    logic signed [PROD_W-1:0] r_p_ii;
    logic signed [PROD_W-1:0] r_p_ri;
    logic [ITER_W-1:0]        r_iter;
    logic                     r_inside;
    logic [SCALED_W-1:0]      r_scaled;

    // Result registers
    logic [COLOUR_W-1:0] r_colour;
    logic                r_inside_out;
    logic [ITER_W-1:0]   r_iter_out;
    logic                r_done;

    logic [MAG2_W-1:0]           mag2;
    logic [2*LIMIT_W-1:0]        lim_sq;
    logic [MAG2_W-1:0]           lim2;
    logic                        below;
    logic signed [PROD_W-1:0]    diff;
    logic signed [Z_W-1:0]       n_zr;
    logic signed [Z_W-1:0]       n_zi;
    logic [ROOT_W-1:0]           root;
    logic                        root_busy;
    logic [ROOT_W+SCALE_W-1:0]   scale_prod;
    logic [COLOUR_W-1:0]         scaled_ext;

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_start  <= RST_X_START;
            r_y_end    <= RST_Y_END;
            r_x_step   <= RST_X_STEP;
            r_y_step   <= RST_Y_STEP;
            r_max_iter <= RST_MAX_ITER;
            r_limit    <= RST_LIMIT;
            r_in_base  <= RST_INSIDE_BASE;
            r_out_base <= RST_OUT_BASE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_X_START:     r_x_start  <= i_cfg_wdata;
                CFG_Y_END:       r_y_end    <= i_cfg_wdata;
                CFG_X_STEP:      r_x_step   <= i_cfg_wdata[STEP_W-1:0];
                CFG_Y_STEP:      r_y_step   <= i_cfg_wdata[STEP_W-1:0];
                CFG_MAX_ITER:    r_max_iter <= i_cfg_wdata[ITER_W-1:0];
                CFG_LIMIT:       r_limit    <= i_cfg_wdata[LIMIT_W-1:0];
                CFG_INSIDE_BASE: r_in_base  <= i_cfg_wdata;
                CFG_OUT_BASE:    r_out_base <= i_cfg_wdata;
                default:         r_limit    <= r_limit;
            endcase
        end
    end

    // |z|^2 of the current z and the escape bound, both Q.24
    assign mag2   = MAG2_W'(r_p_rr[PROD_W-1:FRAC_BITS]) + MAG2_W'(r_p_ii[PROD_W-1:FRAC_BITS]);
    assign lim_sq = r_limit * r_limit;
    assign lim2   = MAG2_W'(lim_sq) << FRAC_BITS;
    assign below  = (mag2 < lim2);

    // Next z: floor of the product terms plus c
    assign diff = r_p_rr - r_p_ii;
    assign n_zr = Z_W'(diff >>> FRAC_BITS) + Z_W'(r_cr);
    assign n_zi = Z_W'(r_p_ri >>> (FRAC_BITS - 1)) + Z_W'(r_ci);

    assign o_sts.go        = (r_iter < r_max_iter) && below;
    assign o_sts.root_busy = root_busy;

    // Capture the pixel, map it to c, run the iteration
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_col  <= COORD_W'(32'(i_column) % IMAGE_WIDTH);
            r_row  <= COORD_W'(32'(i_row) % IMAGE_HEIGHT);
            r_zr   <= '0;
            r_zi   <= '0;
            r_iter <= '0;
        end
        if (i_cmd.setup) begin
            r_cr <= r_x_start + FIX_W'(r_col) * FIX_W'(r_x_step);
            r_ci <= r_y_end - FIX_W'(r_row) * FIX_W'(r_y_step);
        end
        if (i_cmd.mul) begin
            r_p_rr <= r_zr * r_zr;
            r_p_ii <= r_zi * r_zi;
            r_p_ri <= r_zr * r_zi;
        end
        if (i_cmd.step) begin
            r_zr   <= n_zr;
            r_zi   <= n_zi;
            r_iter <= r_iter + 1'b1;
        end
        if (i_cmd.sqrt_start) begin
            r_inside <= below;
        end
        if (i_cmd.scale) begin
            r_scaled <= scale_prod[ROOT_W+SCALE_W-1:SCALE_SHIFT];
        end
    end

    // Modulus in Q.20
    mbrot_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_start),
        .i_radicand (RAD_W'({mag2, SQRT_PRE'(0)})),
        .o_root     (root),
        .o_busy     (root_busy)
    );

    assign scale_prod = root * COLOUR_SCALE;
    assign scaled_ext = COLOUR_W'(r_scaled);

    // Form the colour and strobe the result beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_colour     <= r_inside ? (r_in_base - scaled_ext) : (r_out_base + scaled_ext);
            r_inside_out <= r_inside;
            r_iter_out   <= r_iter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
        end
    end

    assign o_colour          = r_colour;
    assign o_inside_res      = r_inside_out;
    assign o_iterations_done = r_iter_out;
    assign o_done            = r_done;

    `MBROT_ASSERT_NEXT(a_done_one_beat, r_done, !r_done, "result strobe longer than one cycle")

endmodule

// File: design/mandelbrot_escape_time_pixel_unit.sv
// Escape-time pixel unit: pulse start with a column and row while busy is low; the unit
// maps the pixel to c, iterates z = z*z + c, takes the modulus and returns a colour word,
// the inside flag and the step count as one beat on o_done, shown for exactly one cycle
// and not held. The strobe rises at the same edge at which busy falls. Each step passes
// through the registered complex multiplier in the MUL and STEP states, and the modulus
// comes from the bit-serial square-root unit. Write configuration only while busy is low.
module mandelbrot_escape_time_pixel_unit
    import mbrot_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [FIX_W-1:0]     i_cfg_wdata,
    input  logic                 start,
    input  logic [COORD_W-1:0]   i_column,
    input  logic [COORD_W-1:0]   i_row,
    output logic                 busy,
    output logic                 o_done,
    output logic [COLOUR_W-1:0]  o_colour,
    output logic                 o_inside_res,
    output logic [ITER_W-1:0]    o_iterations_done
);

    t_cmd cmd;
    t_sts sts;

    mbrot_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    mbrot_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_column          (i_column),
        .i_row             (i_row),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_colour          (o_colour),
        .o_inside_res      (o_inside_res),
        .o_iterations_done (o_iterations_done),
        .o_done            (o_done)
    );

endmodule

// File: sim/tb_mandelbrot_escape_time_pixel_unit.sv
module tb_mandelbrot_escape_time_pixel_unit;
    import mbrot_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;
    // Longest pixel runs the full cap of 255 steps; the strobe rises as busy falls
    localparam int SETTLE_CYCLES = 600;

    typedef enum logic [1:0] {
        PLAN_PIXEL,
        PLAN_CFG,
        PLAN_DRAIN
    } t_plan_kind;

    typedef struct packed {
        t_plan_kind         kind;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        t_cfg_idx           idx;
        logic [FIX_W-1:0]   data;
    } t_plan_beat;

    typedef struct packed {
        logic [COLOUR_W-1:0] colour;
        logic                in_set;
        logic [ITER_W-1:0]   iters;
    } t_pixel_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [FIX_W-1:0]     i_cfg_wdata = '0;
    logic                 start       = 1'b0;
    logic [COORD_W-1:0]   i_column    = '0;
    logic [COORD_W-1:0]   i_row       = '0;
    logic                 busy;
    logic                 o_done;
    logic [COLOUR_W-1:0]  o_colour;
    logic                 o_inside_res;
    logic [ITER_W-1:0]    o_iterations_done;

    // Shadow copy of the configuration registers
    logic [FIX_W-1:0]    cfg_x_start  = RST_X_START;
    logic [FIX_W-1:0]    cfg_y_end    = RST_Y_END;
    logic [STEP_W-1:0]   cfg_x_step   = RST_X_STEP;
    logic [STEP_W-1:0]   cfg_y_step   = RST_Y_STEP;
    logic [ITER_W-1:0]   cfg_max_iter = RST_MAX_ITER;
    logic [LIMIT_W-1:0]  cfg_limit    = RST_LIMIT;
    logic [COLOUR_W-1:0] cfg_in_base  = RST_INSIDE_BASE;
    logic [COLOUR_W-1:0] cfg_out_base = RST_OUT_BASE;

    t_plan_beat    plan_q[$];
    t_pixel_result colour_q[$];
    int unsigned   mismatch_cnt = 0;
    int unsigned   burst_left   = 0;
    int unsigned   gap_left     = 0;
    int unsigned   stall_cnt    = 0;

    mandelbrot_escape_time_pixel_unit u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .start             (start),
        .i_column          (i_column),
        .i_row             (i_row),
        .busy              (busy),
        .o_done            (o_done),
        .o_colour          (o_colour),
        .o_inside_res      (o_inside_res),
        .o_iterations_done (o_iterations_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Update the shadow registers; bits above each register's width drop
    function automatic void apply_cfg(input t_cfg_idx idx, input logic [FIX_W-1:0] data);
        case (idx)
            CFG_X_START:     cfg_x_start  = data;
            CFG_Y_END:       cfg_y_end    = data;
            CFG_X_STEP:      cfg_x_step   = data[STEP_W-1:0];
            CFG_Y_STEP:      cfg_y_step   = data[STEP_W-1:0];
            CFG_MAX_ITER:    cfg_max_iter = data[ITER_W-1:0];
            CFG_LIMIT:       cfg_limit    = data[LIMIT_W-1:0];
            CFG_INSIDE_BASE: cfg_in_base  = data;
            CFG_OUT_BASE:    cfg_out_base = data;
            default: ;
        endcase
    endfunction

    // Escape-time iteration, modulus and colour for one pixel
    function automatic t_pixel_result escape_pixel(input logic [COORD_W-1:0] col,
                                                   input logic [COORD_W-1:0] row);
        logic [FIX_W-1:0]   cr_w;
        logic [FIX_W-1:0]   ci_w;
        logic signed [95:0] cr;
        logic signed [95:0] ci;
        logic signed [95:0] zr;
        logic signed [95:0] zi;
        logic signed [95:0] nr;
        logic signed [95:0] ni;
        logic signed [95:0] m2;
        logic signed [95:0] lim2;
        logic [63:0]        rad;
        logic [63:0]        sqrt_acc;
        logic [63:0]        probe;
        logic [63:0]        scaled;
        int unsigned        n_iter;
        t_pixel_result      res;
        // c wraps to 32 bits before it is widened
        cr_w = cfg_x_start + 32'(64'(col) * 64'(cfg_x_step));
        ci_w = cfg_y_end - 32'(64'(row) * 64'(cfg_y_step));
        cr = $signed(cr_w);
        ci = $signed(ci_w);
        lim2 = cfg_limit * cfg_limit;
        lim2 = lim2 <<< FRAC_BITS;
        zr = 0;
        zi = 0;
        m2 = 0;
        n_iter = 0;
        // Zero iteration cap or zero limit: loop never runs
        while (n_iter < cfg_max_iter && m2 < lim2) begin
            nr = ((zr * zr - zi * zi) >>> FRAC_BITS) + cr;
            ni = ((2 * zr * zi) >>> FRAC_BITS) + ci;
            zr = nr;
            zi = ni;
            m2 = ((zr * zr) >>> FRAC_BITS) + ((zi * zi) >>> FRAC_BITS);
            n_iter++;
        end
        res.in_set = (m2 < lim2);
        // Integer square root of |z|^2 scaled up, one digit pair per pass
        rad = m2[63:0] << SQRT_PRE;
        sqrt_acc = '0;
        probe = 64'd1 << 62;
        while (probe > rad)
            probe = probe >> 2;
        while (probe != 0) begin
            if (rad >= sqrt_acc + probe) begin
                rad = rad - (sqrt_acc + probe);
                sqrt_acc = (sqrt_acc >> 1) + probe;
            end else begin
                sqrt_acc = sqrt_acc >> 1;
            end
            probe = probe >> 2;
        end
        scaled = (sqrt_acc * COLOUR_SCALE) >> SCALE_SHIFT;
        res.colour = res.in_set ? cfg_in_base - scaled[31:0] : cfg_out_base + scaled[31:0];
        res.iters = n_iter[ITER_W-1:0];
        return res;
    endfunction

    // Mostly short gaps, a few long ones, and runs with none at all
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (burst_left != 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            burst_left = $urandom_range(8, 30);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 250);
    endfunction

    task automatic add_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
        t_plan_beat b;
        b = '0;
        b.kind = PLAN_PIXEL;
        b.column = col;
        b.row = row;
        plan_q.push_back(b);
    endtask

    task automatic add_cfg(input t_cfg_idx idx, input logic [FIX_W-1:0] data);
        t_plan_beat b;
        b = '0;
        b.kind = PLAN_CFG;
        b.idx = idx;
        b.data = data;
        plan_q.push_back(b);
    endtask

    task automatic add_drain();
        t_plan_beat b;
        b = '0;
        b.kind = PLAN_DRAIN;
        plan_q.push_back(b);
    endtask

    // Hold off until all pixels are back, then load a full register set
    task automatic add_settings(input int x0, input int y0, input int unsigned dx,
                                input int unsigned dy, input int unsigned iters,
                                input int unsigned lim);
        add_drain();
        add_cfg(CFG_X_START, 32'(x0));
        add_cfg(CFG_Y_END, 32'(y0));
        add_cfg(CFG_X_STEP, {$urandom_range(0, 1) == 1, 31'(dx)});
        add_cfg(CFG_Y_STEP, {$urandom_range(0, 1) == 1, 31'(dy)});
        add_cfg(CFG_MAX_ITER, {24'($urandom), 8'(iters)});
        add_cfg(CFG_LIMIT, {28'($urandom), 4'(lim)});
        add_cfg(CFG_INSIDE_BASE, $urandom);
        add_cfg(CFG_OUT_BASE, $urandom);
    endtask

    // Random pixels over the current window, with the odd full drain
    task automatic add_random_pixels(input int unsigned count);
        for (int unsigned k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 4)
                add_drain();
            add_pixel(10'($urandom), 10'($urandom));
        end
    endtask

    // Driver: present pixels and register writes from the plan
    always @(posedge i_clk) begin : drive_blk
        logic       took;
        logic       quiet;
        logic       nxt_start;
        logic       nxt_we;
        t_plan_beat ent;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            took = start && !busy;
            if (took)
                colour_q.push_back(escape_pixel(i_column, i_row));
            nxt_start = start && !took;
            nxt_we = 1'b0;
            quiet = !took && !start && !busy && colour_q.size() == 0;
            if (!nxt_start) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (plan_q.size() != 0) begin
                    ent = plan_q[0];
                    case (ent.kind)
                        PLAN_PIXEL: begin
                            void'(plan_q.pop_front());
                            i_column <= ent.column;
                            i_row <= ent.row;
                            nxt_start = 1'b1;
                            gap_left = pick_gap();
                        end
                        PLAN_CFG: begin
                            if (quiet) begin
                                void'(plan_q.pop_front());
                                nxt_we = 1'b1;
                                i_cfg_idx <= ent.idx;
                                i_cfg_wdata <= ent.data;
                                apply_cfg(ent.idx, ent.data);
                            end
                        end
                        default: begin
                            if (quiet) begin
                                void'(plan_q.pop_front());
                                gap_left = $urandom_range(0, 4);
                            end
                        end
                    endcase
                end
            end
            start <= nxt_start;
            i_cfg_we <= nxt_we;
        end
    end

    // Monitor: check each result beat against the oldest prediction
    always @(posedge i_clk) begin : check_blk
        t_pixel_result want;
        if (i_rst_n && o_done) begin
            if (colour_q.size() == 0) begin
                $display("%0t: unexpected result colour=%h inside=%0d iters=%0d",
                         $time, o_colour, o_inside_res, o_iterations_done);
                mismatch_cnt++;
            end else begin
                want = colour_q.pop_front();
                if (o_colour !== want.colour) begin
                    $display("%0t: colour expected %h actual %h", $time, want.colour, o_colour);
                    mismatch_cnt++;
                end
                if (o_inside_res !== want.in_set) begin
                    $display("%0t: inside_res expected %0d actual %0d",
                             $time, want.in_set, o_inside_res);
                    mismatch_cnt++;
                end
                if (o_iterations_done !== want.iters) begin
                    $display("%0t: iterations_done expected %0d actual %0d",
                             $time, want.iters, o_iterations_done);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done || i_cfg_we)
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("tb_mandelbrot_escape_time_pixel_unit: errors");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;

        // Reset window: corners and the origin
        add_pixel(10'd0, 10'd0);
        add_pixel(10'd1023, 10'd1023);
        add_pixel(10'd1023, 10'd0);
        add_pixel(10'd0, 10'd1023);
        add_pixel(10'd512, 10'd512);

        // Zero iteration cap, then the full cap on a point that never escapes
        add_drain();
        add_cfg(CFG_MAX_ITER, 32'd0);
        add_pixel(10'd300, 10'd400);
        add_cfg(CFG_MAX_ITER, 32'd255);
        add_pixel(10'd512, 10'd512);
        add_pixel(10'd0, 10'd0);

        // Zero escape limit, then a limit of 10
        add_drain();
        add_cfg(CFG_LIMIT, 32'd0);
        add_pixel(10'd512, 10'd512);
        add_cfg(CFG_LIMIT, 32'd10);
        add_pixel(10'd512, 10'd512);
        add_pixel(10'd700, 10'd300);

        // Extreme registers: wrapping coordinates, oversize step writes
        add_drain();
        add_cfg(CFG_X_START, 32'h8000_0000);
        add_cfg(CFG_Y_END, 32'h7FFF_FFFF);
        add_cfg(CFG_X_STEP, 32'hFFFF_FFFF);
        add_cfg(CFG_Y_STEP, 32'hFFFF_FFFF);
        add_cfg(CFG_MAX_ITER, 32'd1);
        add_cfg(CFG_LIMIT, 32'd1);
        add_cfg(CFG_INSIDE_BASE, 32'd0);
        add_cfg(CFG_OUT_BASE, 32'hFFFF_FFFF);
        add_pixel(10'd0, 10'd0);
        add_pixel(10'd1023, 10'd1023);
        add_pixel(10'd1, 10'd1);
        add_pixel(10'd1023, 10'd0);
        add_pixel(10'd682, 10'd341);

        // Deep iteration cap on a classic window, few pixels
        add_settings(-(5 <<< 23) + int'($urandom_range(0, 1 << 25)),
                     (1 << 23) + int'($urandom_range(0, 1 << 24)),
                     $urandom_range(0, 49152), $urandom_range(0, 49152),
                     255, $urandom_range(1, 10));
        add_random_pixels(16);

        // Windows over the set boundary, moderate caps
        for (int p = 0; p < 7; p++) begin
            add_settings(-(5 <<< 23) + int'($urandom_range(0, 1 << 25)),
                         (1 << 23) + int'($urandom_range(0, 1 << 24)),
                         (p % 3 == 0) ? $urandom_range(0, 1024) : $urandom_range(0, 49152),
                         (p % 3 == 0) ? $urandom_range(0, 1024) : $urandom_range(0, 49152),
                         $urandom_range(1, 64), $urandom_range(1, 10));
            add_random_pixels(50);
        end

        // Arbitrary registers, coordinates free to wrap
        add_settings(int'($urandom), int'($urandom), $urandom, $urandom,
                     $urandom_range(0, 40), $urandom_range(0, 10));
        add_random_pixels(30);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (plan_q.size() != 0 || colour_q.size() != 0 || start);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("tb_mandelbrot_escape_time_pixel_unit: clean");
        else
            $display("tb_mandelbrot_escape_time_pixel_unit: errors");
        $finish;
    end

endmodule
